@@ rtl/core/dsem_pkg.sv @@
`timescale 1ns / 1ps

package dsem_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int K_W   = 34;
    localparam int D_W   = 24;
    localparam int DT_W  = 32;
    localparam int CFG_W = 34;
    localparam int IDX_W = 2;
    localparam int POS_W = 40;
    localparam int VEL_W = 48;
    localparam int ERR_W = 42;
    localparam int LOG_W = 24;

    localparam int MA_W = 80;
    localparam int MB_W = 64;
    localparam int P_W  = 128;

    localparam logic [IDX_W-1:0] REG_STIFFNESS = 2'd0;
    localparam logic [IDX_W-1:0] REG_DAMPING   = 2'd1;
    localparam logic [IDX_W-1:0] REG_TIME_STEP = 2'd2;

    localparam logic [K_W-1:0]  K_RESET  = 34'd0;
    localparam logic [D_W-1:0]  D_RESET  = 24'd12800;
    localparam logic [DT_W-1:0] DT_RESET = 32'd97391;

    localparam logic [MB_W-1:0]  LOG10_2_Q32  = 64'd1292913986;
    localparam logic [LOG_W-1:0] LOG_MIN_CODE = 24'h800000;

    typedef struct packed {
        logic            start;
        logic [MA_W-1:0] a;
        logic [MB_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic           done;
        logic [P_W-1:0] p;
    } mul_rsp_t;

    typedef struct packed {
        logic           start;
        logic [P_W-1:0] n;
        logic [K_W-1:0] d;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [P_W-1:0] q;
    } div_rsp_t;

endpackage

@@ rtl/core/damped_spring_energy_meter_top.sv @@
`timescale 1ns / 1ps
// channel | ports                     | content
// ------- | ------------------------- | ------------------------------------------
// in      | s_axis_t{valid,ready}     | tdata: sample; tlast: last_in_block
// out     | m_axis_t{valid,ready}     | tdata: log_energy; tuser: energy_invalid
// cfg     | cfg_we, cfg_index         | cfg_data: register value, no read-back
//
// One sample at a time through a shift-add multiplier (one bit per cycle) and a
// bit-serial divider. An update runs the multiplies d*v, k*e, acc*dt and v*dt.
// A block-end sample with nonzero k adds two squarings, a divide, a normalize,
// a squaring loop and a log multiply. Busy while working; tready low meanwhile.
// Reset clears state and registers to defaults; no clearing pass.
// A finished result waits in the output register while the next sample runs.

module damped_spring_energy_meter_top
    import dsem_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,  // [SW-1:0] sample
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [LOG_W-1:0]                  m_axis_tdata,  // [23:0] log_energy
    output logic [0:0]                        m_axis_tuser,  // [0] energy_invalid
    input  logic                              cfg_we,
    input  logic [IDX_W-1:0]                  cfg_index,
    input  logic [CFG_W-1:0]                  cfg_data
);

    localparam int SHIFT = 33 - SAMPLE_WIDTH;
    localparam int S_W   = 41;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DV   = 4'd1;
    localparam logic [3:0] ST_KE   = 4'd2;
    localparam logic [3:0] ST_AT   = 4'd3;
    localparam logic [3:0] ST_VT   = 4'd4;
    localparam logic [3:0] ST_E2   = 4'd5;
    localparam logic [3:0] ST_V2   = 4'd6;
    localparam logic [3:0] ST_DIV  = 4'd7;
    localparam logic [3:0] ST_NORM = 4'd8;
    localparam logic [3:0] ST_SQ   = 4'd9;
    localparam logic [3:0] ST_LOG  = 4'd10;
    localparam logic [3:0] ST_OUT  = 4'd11;

    logic [3:0]             state_reg, state_next;
    logic [K_W-1:0]         k_reg;
    logic [D_W-1:0]         d_reg;
    logic [DT_W-1:0]        dt_reg;
    logic signed [POS_W-1:0] x_reg, x_next;
    logic signed [VEL_W-1:0] v_reg, v_next;
    logic signed [S_W-1:0]  s_reg, s_next;
    logic                   last_reg, last_next;
    logic signed [ERR_W-1:0] e_reg, e_next;
    logic [P_W-1:0]         p1_reg, p1_next;
    logic                   an_reg, an_next;
    logic [P_W-1:0]         en_reg, en_next;
    logic [6:0]             cnt_reg, cnt_next;
    logic [4:0]             it_reg, it_next;
    logic [23:0]            frac_reg, frac_next;
    logic                   ln_reg, ln_next;
    logic [LOG_W-1:0]       res_reg, res_next;
    logic                   inv_reg, inv_next;
    logic                   ov_reg, ov_next;
    logic [LOG_W-1:0]       od_reg, od_next;
    logic                   of_reg, of_next;
    mul_req_t               mreq_reg, mreq_next;
    div_req_t               dreq_reg, dreq_next;
    mul_rsp_t               mrsp;
    div_rsp_t               drsp;

    logic signed [S_W-1:0]   s_in;
    logic [VEL_W-1:0]        v_mag;
    logic [ERR_W-1:0]        e_mag;
    logic signed [P_W-1:0]   p2s, accs, dvs, vsum, dxs, xsum, prods;
    logic [P_W-1:0]          acc_mag;
    logic signed [VEL_W-1:0] vn;
    logic [VEL_W-1:0]        vn_mag;
    logic signed [POS_W-1:0] xn;
    logic signed [ERR_W-1:0] en_err;
    logic [ERR_W-1:0]        en_err_mag;
    logic [31:0]             sq_t;
    logic [30:0]             m_new;
    logic [23:0]             frac_new;
    logic [6:0]              pe;
    logic signed [30:0]      l_val;
    logic [30:0]             l_mag;

    dsem_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq_reg), .rsp(mrsp));
    dsem_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq_reg), .rsp(drsp));

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = of_reg;

    always_comb
    begin
        s_in   = S_W'($signed(s_axis_tdata[SAMPLE_WIDTH-1:0])) <<< SHIFT;
        v_mag  = v_reg[VEL_W-1] ? VEL_W'(-v_reg) : VEL_W'(v_reg);
        e_mag  = e_reg[ERR_W-1] ? ERR_W'(-e_reg) : ERR_W'(e_reg);
        p2s    = e_reg[ERR_W-1] ? -$signed(mrsp.p) : $signed(mrsp.p);
        accs   = -($signed(p1_reg) + p2s);
        acc_mag = accs[P_W-1] ? P_W'(-accs) : P_W'(accs);
        dvs    = (an_reg ? -$signed(mrsp.p) : $signed(mrsp.p)) >>> 40;
        vsum   = dvs + P_W'(v_reg);
        if (vsum > $signed(P_W'((64'd1 << (VEL_W-1)) - 64'd1)))
        begin
            vn = {1'b0, {(VEL_W-1){1'b1}}};
        end
        else if (vsum < -$signed(P_W'(64'd1 << (VEL_W-1))))
        begin
            vn = {1'b1, {(VEL_W-1){1'b0}}};
        end
        else
        begin
            vn = vsum[VEL_W-1:0];
        end
        vn_mag = vn[VEL_W-1] ? VEL_W'(-vn) : VEL_W'(vn);
        dxs    = (v_reg[VEL_W-1] ? -$signed(mrsp.p) : $signed(mrsp.p)) >>> 24;
        xsum   = dxs + P_W'(x_reg);
        if (xsum > $signed(P_W'((64'd1 << (POS_W-1)) - 64'd1)))
        begin
            xn = {1'b0, {(POS_W-1){1'b1}}};
        end
        else if (xsum < -$signed(P_W'(64'd1 << (POS_W-1))))
        begin
            xn = {1'b1, {(POS_W-1){1'b0}}};
        end
        else
        begin
            xn = xsum[POS_W-1:0];
        end
        en_err     = ERR_W'(xn) - ERR_W'(s_reg);
        en_err_mag = en_err[ERR_W-1] ? ERR_W'(-en_err) : ERR_W'(en_err);
        sq_t       = mrsp.p[61:30];
        m_new      = sq_t[31] ? sq_t[31:1] : sq_t[30:0];
        frac_new   = {frac_reg[22:0], sq_t[31]};
        pe         = 7'd63 - cnt_reg;
        l_val      = {pe, frac_new};
        l_mag      = l_val[30] ? 31'(-l_val) : 31'(l_val);
        prods      = ln_reg ? -$signed(mrsp.p) : $signed(mrsp.p);
    end

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        v_next     = v_reg;
        s_next     = s_reg;
        last_next  = last_reg;
        e_next     = e_reg;
        p1_next    = p1_reg;
        an_next    = an_reg;
        en_next    = en_reg;
        cnt_next   = cnt_reg;
        it_next    = it_reg;
        frac_next  = frac_reg;
        ln_next    = ln_reg;
        res_next   = res_reg;
        inv_next   = inv_reg;
        mreq_next  = mreq_reg;
        dreq_next  = dreq_reg;
        mreq_next.start = 1'b0;
        dreq_next.start = 1'b0;
        ov_next    = ov_reg && !m_axis_tready;
        od_next    = od_reg;
        of_next    = of_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    s_next    = s_in;
                    last_next = s_axis_tlast;
                    e_next    = ERR_W'(x_reg) - ERR_W'(s_in);
                    mreq_next = '{start: 1'b1, a: MA_W'(v_mag), b: MB_W'(d_reg)};
                    state_next = ST_DV;
                end
            end
            ST_DV:
            begin
                if (mrsp.done)
                begin
                    p1_next   = v_reg[VEL_W-1] ? P_W'(-mrsp.p) : mrsp.p;
                    mreq_next = '{start: 1'b1, a: MA_W'(e_mag), b: MB_W'(k_reg)};
                    state_next = ST_KE;
                end
            end
            ST_KE:
            begin
                if (mrsp.done)
                begin
                    an_next   = accs[P_W-1];
                    mreq_next = '{start: 1'b1, a: acc_mag[MA_W-1:0], b: MB_W'(dt_reg)};
                    state_next = ST_AT;
                end
            end
            ST_AT:
            begin
                if (mrsp.done)
                begin
                    v_next    = vn;
                    mreq_next = '{start: 1'b1, a: MA_W'(vn_mag), b: MB_W'(dt_reg)};
                    state_next = ST_VT;
                end
            end
            ST_VT:
            begin
                if (mrsp.done)
                begin
                    x_next = xn;
                    if (!last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (k_reg == '0)
                    begin
                        res_next   = LOG_MIN_CODE;
                        inv_next   = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        mreq_next = '{start: 1'b1, a: MA_W'(en_err_mag),
                                      b: MB_W'(en_err_mag)};
                        state_next = ST_E2;
                    end
                end
            end
            ST_E2:
            begin
                if (mrsp.done)
                begin
                    en_next   = mrsp.p;
                    mreq_next = '{start: 1'b1, a: MA_W'(v_mag), b: MB_W'(v_mag)};
                    state_next = ST_V2;
                end
            end
            ST_V2:
            begin
                if (mrsp.done)
                begin
                    dreq_next = '{start: 1'b1, n: {mrsp.p[P_W-17:0], 16'd0}, d: k_reg};
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (drsp.done)
                begin
                    en_next  = en_reg + drsp.q;
                    cnt_next = '0;
                    if ((en_reg + drsp.q) == '0)
                    begin
                        res_next   = LOG_MIN_CODE;
                        inv_next   = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_NORM;
                    end
                end
            end
            ST_NORM:
            begin
                if (en_reg[P_W-1])
                begin
                    frac_next = '0;
                    it_next   = '0;
                    mreq_next = '{start: 1'b1, a: MA_W'(en_reg[P_W-1:P_W-31]),
                                  b: MB_W'(en_reg[P_W-1:P_W-31])};
                    state_next = ST_SQ;
                end
                else
                begin
                    en_next  = {en_reg[P_W-2:0], 1'b0};
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SQ:
            begin
                if (mrsp.done)
                begin
                    frac_next = frac_new;
                    it_next   = it_reg + 1'b1;
                    if (it_reg == 5'd23)
                    begin
                        ln_next   = l_val[30];
                        mreq_next = '{start: 1'b1, a: MA_W'(l_mag), b: LOG10_2_Q32};
                        state_next = ST_LOG;
                    end
                    else
                    begin
                        mreq_next = '{start: 1'b1, a: MA_W'(m_new), b: MB_W'(m_new)};
                    end
                end
            end
            ST_LOG:
            begin
                if (mrsp.done)
                begin
                    res_next   = prods[63:40];
                    inv_next   = 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next    = 1'b1;
                    od_next    = res_reg;
                    of_next    = inv_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            x_reg     <= '0;
            v_reg     <= '0;
            k_reg     <= K_RESET;
            d_reg     <= D_RESET;
            dt_reg    <= DT_RESET;
            ov_reg    <= 1'b0;
            mreq_reg  <= '0;
            dreq_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            v_reg     <= v_next;
            ov_reg    <= ov_next;
            mreq_reg  <= mreq_next;
            dreq_reg  <= dreq_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STIFFNESS: k_reg  <= cfg_data[K_W-1:0];
                    REG_DAMPING:   d_reg  <= cfg_data[D_W-1:0];
                    REG_TIME_STEP: dt_reg <= cfg_data[DT_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg      <= s_next;
        last_reg   <= last_next;
        e_reg      <= e_next;
        p1_reg     <= p1_next;
        an_reg     <= an_next;
        en_reg     <= en_next;
        cnt_reg    <= cnt_next;
        it_reg     <= it_next;
        frac_reg   <= frac_next;
        ln_reg     <= ln_next;
        res_reg    <= res_next;
        inv_reg    <= inv_next;
        od_reg     <= od_next;
        of_reg     <= of_next;
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> state_reg == ST_DV)
        else $error("accepted sample did not start the update");

    a_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
        mrsp.done |-> state_reg != ST_IDLE && state_reg != ST_DIV
                      && state_reg != ST_NORM && state_reg != ST_OUT)
        else $error("multiplier finished outside a multiply step");

    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !m_axis_tready |=> ov_reg && $stable(od_reg))
        else $error("pending result overwritten");

endmodule

@@ rtl/core/dsem_mul.sv @@
`timescale 1ns / 1ps

module dsem_mul
    import dsem_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic [P_W-1:0]  acc_reg, acc_next;
    logic [P_W-1:0]  a_reg, a_next;
    logic [MB_W-1:0] b_reg, b_next;
    logic            busy_reg, busy_next;

    // shift-add, one multiplier bit per cycle, stops when the rest is zero
    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        busy_next = busy_reg;
        if (req.start)
        begin
            acc_next  = '0;
            a_next    = {{(P_W-MA_W){1'b0}}, req.a};
            b_next    = req.b;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = {a_reg[P_W-2:0], 1'b0};
                b_next = {1'b0, b_reg[MB_W-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign rsp.done = busy_reg && (b_reg == '0);
    assign rsp.p    = acc_reg;

endmodule

@@ rtl/core/dsem_div.sv @@
`timescale 1ns / 1ps

module dsem_div
    import dsem_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(P_W);

    logic [P_W-1:0]   n_reg, n_next;
    logic [P_W-1:0]   q_reg, q_next;
    logic [K_W-1:0]   d_reg, d_next;
    logic [K_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [K_W:0]     trial;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        n_next    = n_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, n_reg[P_W-1]};
        if (req.start)
        begin
            n_next    = req.n;
            d_next    = req.d;
            q_next    = '0;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            n_next = {n_reg[P_W-2:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = K_W'(trial - {1'b0, d_reg});
                q_next   = {q_reg[P_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[K_W-1:0];
                q_next   = {q_reg[P_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(P_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;

endmodule
